// ===== src/assert_macros.svh =====
// assertion macros shared by the card reader channel rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define CRCC_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define CRCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/crcc_pkg.sv =====
// types, codes and the punch decode table for the card reader channel
package crcc_pkg;

	localparam int unsigned CARD_COLUMNS_DEF = 80;

	typedef enum logic [2:0] {
		OP_CONNECT    = 3'd0,
		OP_CONTROL    = 3'd1,
		OP_DISCONNECT = 3'd2,
		OP_SKIP_TEST  = 3'd3,
		OP_READ_CHAR  = 3'd4,
		OP_LOAD_COL   = 3'd5,
		OP_TICK       = 3'd6,
		OP_WRITE      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_WRONG_CH  = 2'd1,
		ERR_BUSY      = 2'd2,
		ERR_WRITE_REJ = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		RS_IDLE    = 2'd0,
		RS_FEEDING = 2'd1,
		RS_READING = 2'd2
	} rstat_t;

	localparam logic [5:0] CTL_SKIP_CARD = 6'd16;
	localparam logic [5:0] SKC_FEED      = 6'd4;
	localparam logic [5:0] SKC_READY     = 6'd8;
	localparam logic [5:0] SKC_FIRST     = 6'd16;

	localparam logic [5:0] CODE_ILLEGAL = 6'o77;
	localparam logic [5:0] CODE_BLANK   = 6'o60;

	// one result transaction
	typedef struct packed {
		logic [5:0] ch;
		logic       chv;
		logic       skip;
		err_t       err;
		logic       eor;
		logic       eflag;
		logic       disc;
		logic       xfer;
	} res_t;

	// hollerith column to six-bit internal code
	function automatic logic [5:0] punch_to_code(input logic [11:0] col);
		logic [6:0] code;
		logic [8:0] rows;
		logic [3:0] msb;
		logic [3:0] nset;
		logic       bad;
		code = '0;
		rows = col[8:0];
		msb  = '0;
		nset = '0;
		bad  = 1'b0;
		case (col[11:9])
			3'b000: code = (col[8:0] == '0) ? {1'b0, CODE_BLANK} : 7'o00;
			3'b001: code = 7'o60;
			3'b010: code = 7'o40;
			3'b011: code = 7'o52;
			3'b100: code = 7'o20;
			3'b101: code = 7'o32;
			default: bad = 1'b1;
		endcase
		// row 8 adds eight, the one remaining row 1..9 adds its number
		if (rows[1]) begin
			code = code + 7'd8;
			rows[1] = 1'b0;
		end
		for (int i = 0; i < 9; i++) begin
			if (rows[i]) begin
				msb  = 4'(i);
				nset = nset + 4'd1;
			end
		end
		if (rows != '0)
			code = code + 7'(4'd9 - msb);
		if (nset > 4'd1)
			bad = 1'b1;
		if (col[11:9] == 3'b000 && col[8:0] == '0)
			return CODE_BLANK;
		if (col[11:9] == 3'b001 && col[8:0] == '0)
			return 6'o00;
		if (bad)
			return CODE_ILLEGAL;
		return code[5:0];
	endfunction

endpackage

// ===== src/card_reader_column_channel_unit.sv =====
// card reader channel top level: reader control around the column store
// results are registered; read char first passes a store read phase
// (column store read, then decode and state update)
// throughput: one transaction per cycle unless a held result stalls; read char stalls its successor
// reset: reader idle, pointer and flags cleared, channel number 0;
// column store contents stay undefined until loaded
`include "assert_macros.svh"

module card_reader_column_channel_unit
	import crcc_pkg::*;
#(
	parameter int unsigned CARD_COLUMNS = CARD_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	// operation channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [2:0]  channel_sel,
	input  logic        binary_mode,
	input  logic [5:0]  control_code,
	input  logic [5:0]  skip_cond,
	input  logic        hopper_has_card,
	input  logic [6:0]  column_index,
	input  logic [11:0] column_data,
	input  logic        card_ok,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  char_out,
	output logic        char_valid,
	output logic        skip_taken,
	output logic [1:0]  error_code,
	output logic        end_of_record,
	output logic        error_flag,
	output logic        disconnect_req,
	output logic        transfer_request
);

	localparam int unsigned AW = (CARD_COLUMNS > 1) ? $clog2(CARD_COLUMNS) : 1;
	localparam int unsigned PW = $clog2(CARD_COLUMNS + 1);

	// sequencing: accept phase, then one store read phase for read char
	typedef enum logic [1:0] {
		PH_IDLE = 2'b01,
		PH_READ = 2'b10
	} ph_t;

	ph_t          ph_q, ph_d;
	logic [2:0]   chan_q;
	rstat_t       status_q, status_d;
	logic [PW-1:0] ptr_q, ptr_d;
	logic         loaded_q, loaded_d;
	logic [7:0]   half_q, half_d;
	logic         sbin_q, sbin_d;
	logic         pend_q, pend_d;
	logic         xfer_q, xfer_d;
	logic         timer_q, timer_d;

	logic         in_fire;
	logic         chan_ok;
	logic         res_load;
	res_t         res;
	res_t         res_q;
	op_t          op;
	logic [PW-1:0] ptr_eff;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [11:0]   mem_rdata;

	// stall while a read is in flight or the result register cannot drain
	assign in_stall = !(ph_q == PH_IDLE && (!out_valid || !out_stall));
	assign in_fire  = in_valid && !in_stall;
	assign chan_ok  = (channel_sel == chan_q);
	assign op       = op_t'(opcode);

	// a read on an unloaded card starts at column zero
	assign ptr_eff   = loaded_q ? ptr_q : '0;
	assign mem_raddr = ptr_eff[AW-1:0];
	assign mem_we    = in_fire && op == OP_LOAD_COL && 32'(column_index) < CARD_COLUMNS;

	// the store is written only in the accept phase and read one phase later,
	// so a load followed by a read always sees the new column
	crcc_colmem #(
		.CARD_COLUMNS(CARD_COLUMNS)
	) u_colmem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (column_index[AW-1:0]),
		.wdata (column_data),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		ph_d     = ph_q;
		status_d = status_q;
		ptr_d    = ptr_q;
		loaded_d = loaded_q;
		half_d   = half_q;
		sbin_d   = sbin_q;
		pend_d   = pend_q;
		xfer_d   = xfer_q;
		timer_d  = timer_q;
		res      = '0;
		res.err  = ERR_OK;
		res_load = 1'b0;
		mem_re   = 1'b0;
		unique case (ph_q)
			PH_IDLE: begin
				if (in_fire) begin
					res_load = 1'b1;
					unique case (op)
						OP_CONNECT: begin
							if (!chan_ok) begin
								res.err = ERR_WRONG_CH;
							end else if (timer_q) begin
								res.err = ERR_BUSY;
							end else begin
								if (status_q == RS_IDLE && hopper_has_card) begin
									// start feeding a new card
									status_d = RS_FEEDING;
									loaded_d = 1'b0;
									ptr_d    = '0;
									xfer_d   = 1'b0;
									timer_d  = 1'b1;
								end else if (binary_mode != sbin_q) begin
									// mode change: leaving binary mid-column skips its low half
									if (sbin_q && half_q[0] && 32'(ptr_q) < CARD_COLUMNS)
										ptr_d = ptr_q + PW'(1);
									half_d = '0;
								end
								sbin_d = binary_mode;
							end
						end
						OP_CONTROL: begin
							if (!chan_ok) begin
								res.err = ERR_WRONG_CH;
							end else if (control_code == CTL_SKIP_CARD) begin
								// skip the rest of the card
								timer_d   = 1'b0;
								status_d  = RS_IDLE;
								xfer_d    = 1'b0;
								res.eor   = 1'b1;
								res.disc  = 1'b1;
							end
						end
						OP_DISCONNECT: begin
							// no channel check here
							xfer_d  = 1'b0;
							timer_d = 1'b0;
						end
						OP_SKIP_TEST: begin
							if (!chan_ok) begin
								res.err = ERR_WRONG_CH;
							end else if (skip_cond == SKC_FEED || skip_cond == SKC_READY) begin
								res.skip = (status_q == RS_IDLE) && hopper_has_card;
							end else if (skip_cond == SKC_FIRST) begin
								res.skip = (status_q == RS_READING) &&
									((sbin_q && half_q < 8'd2) || half_q < 8'd1);
							end
						end
						OP_READ_CHAR: begin
							xfer_d = 1'b0;
							if (!loaded_q && !card_ok) begin
								// failed card fetch ends the record with an error
								status_d  = RS_IDLE;
								timer_d   = 1'b0;
								ptr_d     = '0;
								res.eor   = 1'b1;
								res.eflag = 1'b1;
								res.disc  = 1'b1;
							end else begin
								if (!loaded_q) begin
									status_d = RS_READING;
									ptr_d    = '0;
									loaded_d = 1'b1;
									half_d   = '0;
								end
								// fetch the column, finish in the read phase
								mem_re   = 32'(ptr_eff) < CARD_COLUMNS;
								ph_d     = PH_READ;
								res_load = 1'b0;
							end
						end
						OP_LOAD_COL: begin
							// store write happens on mem_we
						end
						OP_TICK: begin
							if (timer_q) begin
								xfer_d = 1'b1;
								if (pend_q) begin
									// end of card reached on the previous read
									xfer_d   = 1'b0;
									pend_d   = 1'b0;
									timer_d  = 1'b0;
									status_d = RS_IDLE;
									res.eor  = 1'b1;
								end
							end
						end
						OP_WRITE: begin
							res.err = ERR_WRITE_REJ;
						end
						default: begin
							res.err = ERR_WRITE_REJ;
						end
					endcase
				end
			end
			PH_READ: begin
				res_load = 1'b1;
				ph_d     = PH_IDLE;
				if (32'(ptr_q) < CARD_COLUMNS) begin
					res.chv = 1'b1;
					if (sbin_q) begin
						// binary: high half first, then low half and advance
						if (half_q[0]) begin
							res.ch = mem_rdata[5:0];
							ptr_d  = ptr_q + PW'(1);
						end else begin
							res.ch = mem_rdata[11:6];
						end
						half_d = half_q + 8'd1;
					end else begin
						res.ch = punch_to_code(mem_rdata);
						ptr_d  = ptr_q + PW'(1);
					end
				end
				// last column taken: end of record on the next tick
				if (32'(ptr_d) >= CARD_COLUMNS) begin
					pend_d  = 1'b1;
					timer_d = 1'b1;
				end
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase
		res.xfer = xfer_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_IDLE;
			chan_q   <= '0;
			status_q <= RS_IDLE;
			ptr_q    <= '0;
			loaded_q <= 1'b0;
			half_q   <= '0;
			sbin_q   <= 1'b0;
			pend_q   <= 1'b0;
			xfer_q   <= 1'b0;
			timer_q  <= 1'b0;
		end else begin
			ph_q     <= ph_d;
			status_q <= status_d;
			ptr_q    <= ptr_d;
			loaded_q <= loaded_d;
			half_q   <= half_d;
			sbin_q   <= sbin_d;
			pend_q   <= pend_d;
			xfer_q   <= xfer_d;
			timer_q  <= timer_d;
			if (cfg_we)
				chan_q <= cfg_wdata;
		end
	end

	// result register parts the two channels
	crcc_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res_d     (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign char_out         = res_q.ch;
	assign char_valid       = res_q.chv;
	assign skip_taken       = res_q.skip;
	assign error_code       = res_q.err;
	assign end_of_record    = res_q.eor;
	assign error_flag       = res_q.eflag;
	assign disconnect_req   = res_q.disc;
	assign transfer_request = res_q.xfer;

	// a read phase always returns to the idle phase
	`CRCC_ASSERT_RST(a_read_one_cycle, ph_q == PH_READ |=> ph_q == PH_IDLE, "read phase stuck")
	// the column pointer never runs past the end of the card
	`CRCC_ASSERT_RST(a_ptr_range, 32'(ptr_q) <= CARD_COLUMNS, "column pointer out of range")
	// a new result only lands in a free or draining result register
	`CRCC_ASSERT_RST(a_no_overwrite, res_load |-> (!out_valid || !out_stall), "result overwritten")
	// a held result blocks new transactions
	`CRCC_ASSERT_ALWAYS(a_hold_stalls, (out_valid && out_stall) |-> in_stall, "accept while result held")

endmodule

// ===== src/crcc_colmem.sv =====
// column store: one write port, one registered read port
module crcc_colmem
	import crcc_pkg::*;
#(
	parameter int unsigned CARD_COLUMNS = CARD_COLUMNS_DEF,
	localparam int unsigned AW = (CARD_COLUMNS > 1) ? $clog2(CARD_COLUMNS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [11:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [11:0]   rdata
);

	logic [11:0] mem [CARD_COLUMNS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== src/crcc_outreg.sv =====
// output register holding one result transaction until it is taken
module crcc_outreg
	import crcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_d,
	input  logic out_stall,
	output logic out_valid,
	output res_t res_q
);

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_d;
	end

	assign out_valid = valid_q;

endmodule

// ===== tb/sv/card_reader_column_channel_unit_test.sv =====
// self-checking testbench for the card reader column channel unit
module card_reader_column_channel_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import crcc_pkg::*;

	localparam int COLS        = CARD_COLUMNS_DEF;
	localparam int PHASE_OPS   = 600;
	localparam int QUIET_LIMIT = 5000;

	// one operation transaction as driven on the operation channel
	typedef struct {
		op_t         op;
		logic [2:0]  chan;
		logic        bin;
		logic [5:0]  ctl;
		logic [5:0]  cond;
		logic        hopper;
		logic [6:0]  cidx;
		logic [11:0] cdata;
		logic        fetch_ok;
	} reader_op_t;

	typedef struct {
		reader_op_t item;
		bit         typed;
		res_t       want;
	} plan_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [2:0]  channel_sel = '0;
	logic        binary_mode = 1'b0;
	logic [5:0]  control_code = '0;
	logic [5:0]  skip_cond = '0;
	logic        hopper_has_card = 1'b0;
	logic [6:0]  column_index = '0;
	logic [11:0] column_data = '0;
	logic        card_ok = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  char_out;
	logic        char_valid;
	logic        skip_taken;
	logic [1:0]  error_code;
	logic        end_of_record;
	logic        error_flag;
	logic        disconnect_req;
	logic        transfer_request;

	// predicted reader state
	logic [2:0]  ch_setting = '0;
	rstat_t      rdr_state = RS_IDLE;
	logic [6:0]  col_ptr = '0;
	logic        card_in = 1'b0;
	logic [7:0]  half_cnt = '0;
	logic        bin_saved = 1'b0;
	logic        eor_pending = 1'b0;
	logic        xfer_level = 1'b0;
	logic        tick_armed = 1'b0;
	logic [11:0] col_image [COLS];
	bit          col_loaded [COLS];

	res_t        expected_results [$];
	plan_entry_t directed_plan [$];
	int unsigned mismatch_count = 0;
	int unsigned accepted_ops = 0;
	int unsigned phase_start = 0;
	int unsigned send_idle_pct = 21;
	int unsigned recv_idle_pct = 46;
	int unsigned quiet_cycles = 0;

	card_reader_column_channel_unit #(
		.CARD_COLUMNS(COLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.channel_sel(channel_sel),
		.binary_mode(binary_mode),
		.control_code(control_code),
		.skip_cond(skip_cond),
		.hopper_has_card(hopper_has_card),
		.column_index(column_index),
		.column_data(column_data),
		.card_ok(card_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.char_valid(char_valid),
		.skip_taken(skip_taken),
		.error_code(error_code),
		.end_of_record(end_of_record),
		.error_flag(error_flag),
		.disconnect_req(disconnect_req),
		.transfer_request(transfer_request)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hollerith punches to the six-bit internal code
	function automatic logic [5:0] hollerith_code(input logic [11:0] col);
		logic [6:0] base;
		logic [8:0] rows;
		int         top;
		int         hits;
		base = '0;
		rows = col[8:0];
		top  = 0;
		hits = 0;
		case (col[11:9])
			3'b000: begin
				if (rows == '0)
					return CODE_BLANK;
				base = 7'o00;
			end
			3'b001: begin
				if (rows == '0)
					return 6'o00;
				base = 7'o60;
			end
			3'b010: base = 7'o40;
			3'b011: base = 7'o52;
			3'b100: base = 7'o20;
			3'b101: base = 7'o32;
			default: return CODE_ILLEGAL;
		endcase
		// row 8 adds eight by itself, at most one more digit row may be punched
		if (rows[1]) begin
			base = base + 7'd8;
			rows[1] = 1'b0;
		end
		for (int b = 0; b < 9; b++) begin
			if (rows[b]) begin
				top  = b;
				hits = hits + 1;
			end
		end
		if (hits > 1)
			return CODE_ILLEGAL;
		if (hits == 1)
			base = base + 7'(9 - top);
		return base[5:0];
	endfunction

	// applies one accepted operation to the predicted state, returns its result
	function automatic res_t advance_reader(input reader_op_t r);
		res_t        o;
		logic        chan_hit;
		logic [11:0] col;
		o = '0;
		chan_hit = (r.chan == ch_setting);
		case (r.op)
			OP_CONNECT: begin
				if (!chan_hit) begin
					o.err = ERR_WRONG_CH;
				end else if (tick_armed) begin
					o.err = ERR_BUSY;
				end else begin
					if (rdr_state == RS_IDLE && r.hopper) begin
						rdr_state  = RS_FEEDING;
						card_in    = 1'b0;
						col_ptr    = '0;
						xfer_level = 1'b0;
						tick_armed = 1'b1;
					end else if (r.bin != bin_saved) begin
						// leaving binary mode halfway through a column skips its low half
						if (bin_saved && half_cnt[0] && col_ptr < COLS)
							col_ptr = col_ptr + 7'd1;
						half_cnt = '0;
					end
					bin_saved = r.bin;
				end
			end
			OP_CONTROL: begin
				if (!chan_hit) begin
					o.err = ERR_WRONG_CH;
				end else if (r.ctl == CTL_SKIP_CARD) begin
					tick_armed = 1'b0;
					rdr_state  = RS_IDLE;
					xfer_level = 1'b0;
					o.eor      = 1'b1;
					o.disc     = 1'b1;
				end
			end
			OP_DISCONNECT: begin
				xfer_level = 1'b0;
				tick_armed = 1'b0;
			end
			OP_SKIP_TEST: begin
				if (!chan_hit)
					o.err = ERR_WRONG_CH;
				else if (r.cond == SKC_FEED || r.cond == SKC_READY)
					o.skip = (rdr_state == RS_IDLE) && r.hopper;
				else if (r.cond == SKC_FIRST)
					o.skip = (rdr_state == RS_READING) &&
						((bin_saved && half_cnt < 8'd2) || half_cnt < 8'd1);
			end
			OP_READ_CHAR: begin
				xfer_level = 1'b0;
				if (!card_in && !r.fetch_ok) begin
					// failed card fetch
					rdr_state  = RS_IDLE;
					tick_armed = 1'b0;
					col_ptr    = '0;
					o.eor      = 1'b1;
					o.eflag    = 1'b1;
					o.disc     = 1'b1;
				end else begin
					if (!card_in) begin
						rdr_state = RS_READING;
						col_ptr   = '0;
						card_in   = 1'b1;
						half_cnt  = '0;
					end
					if (col_ptr < COLS) begin
						col = col_image[col_ptr];
						if (bin_saved) begin
							if (half_cnt[0]) begin
								o.ch = col[5:0];
								col_ptr = col_ptr + 7'd1;
							end else begin
								o.ch = col[11:6];
							end
							half_cnt = half_cnt + 8'd1;
						end else begin
							o.ch = hollerith_code(col);
							col_ptr = col_ptr + 7'd1;
						end
						o.chv = 1'b1;
					end
					if (col_ptr >= COLS) begin
						eor_pending = 1'b1;
						tick_armed  = 1'b1;
					end
				end
			end
			OP_LOAD_COL: begin
				if (r.cidx < COLS) begin
					col_image[r.cidx]  = r.cdata;
					col_loaded[r.cidx] = 1'b1;
				end
			end
			OP_TICK: begin
				if (tick_armed) begin
					xfer_level = 1'b0;
					if (eor_pending) begin
						eor_pending = 1'b0;
						tick_armed  = 1'b0;
						rdr_state   = RS_IDLE;
						o.eor       = 1'b1;
					end else begin
						xfer_level = 1'b1;
					end
				end
			end
			default: o.err = ERR_WRITE_REJ;
		endcase
		o.xfer = xfer_level;
		return o;
	endfunction

	function automatic res_t outcome(input logic [5:0] ch, input logic chv, input logic skip,
			input err_t err, input logic [3:0] flags);
		res_t o;
		o.ch   = ch;
		o.chv  = chv;
		o.skip = skip;
		o.err  = err;
		{o.eor, o.eflag, o.disc, o.xfer} = flags;
		return o;
	endfunction

	function automatic reader_op_t random_op(input op_t op);
		reader_op_t r;
		r.op       = op;
		r.chan     = 3'($urandom());
		r.bin      = 1'($urandom());
		r.ctl      = 6'($urandom());
		r.cond     = 6'($urandom());
		r.hopper   = 1'($urandom());
		r.cidx     = 7'($urandom());
		r.cdata    = 12'($urandom());
		r.fetch_ok = 1'($urandom());
		return r;
	endfunction

	// mostly legal punch patterns, some arbitrary ones
	function automatic logic [11:0] punch_pattern();
		logic [8:0] rows;
		rows = '0;
		if ($urandom_range(9) < 3)
			return 12'($urandom());
		case ($urandom_range(3))
			0: rows = '0;
			1: rows = 9'd1 << $urandom_range(8);
			default: rows = (9'd1 << $urandom_range(8)) | 9'b000000010;
		endcase
		return {3'($urandom_range(7)), rows};
	endfunction

	task automatic plan_row(input op_t op, input logic [2:0] chan, input logic bin,
			input logic hopper, input logic fetch_ok, input logic [5:0] code,
			input logic [6:0] cidx, input logic [11:0] cdata, input bit typed, input res_t want);
		plan_entry_t e;
		e.item.op       = op;
		e.item.chan     = chan;
		e.item.bin      = bin;
		e.item.ctl      = code;
		e.item.cond     = code;
		e.item.hopper   = hopper;
		e.item.cidx     = cidx;
		e.item.cdata    = cdata;
		e.item.fetch_ok = fetch_ok;
		e.typed = typed;
		e.want  = want;
		directed_plan.push_back(e);
	endtask

	// drives one operation transaction and records its expected result on acceptance
	task automatic drive_op(input reader_op_t r, input bit typed, input res_t typed_res);
		res_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= r.op;
		channel_sel     <= r.chan;
		binary_mode     <= r.bin;
		control_code    <= r.ctl;
		skip_cond       <= r.cond;
		hopper_has_card <= r.hopper;
		column_index    <= r.cidx;
		column_data     <= r.cdata;
		card_ok         <= r.fetch_ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = advance_reader(r);
		expected_results.push_back(typed ? typed_res : want);
		if (!(r.op == OP_LOAD_COL && r.cidx >= COLS))
			accepted_ops++;
	endtask

	// never let a read hit a column that holds no punches yet
	task automatic issue_op(input reader_op_t r);
		reader_op_t fill;
		bit         reads;
		int         col;
		reads = 1'b0;
		col   = 0;
		if (r.op == OP_READ_CHAR) begin
			if (!card_in) begin
				reads = r.fetch_ok;
			end else if (col_ptr < COLS) begin
				reads = 1'b1;
				col   = col_ptr;
			end
		end
		if (reads && !col_loaded[col]) begin
			fill = random_op(OP_LOAD_COL);
			fill.cidx  = 7'(col);
			fill.cdata = punch_pattern();
			drive_op(fill, 1'b0, '0);
		end
		drive_op(r, 1'b0, '0);
	endtask

	// sender holds off until every outstanding result has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_channel(input logic [2:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		ch_setting = value;
	endtask

	// one card from connect through the last column, with detours
	task automatic read_one_card();
		reader_op_t r;
		int         steps;
		repeat ($urandom_range(6)) begin
			r = random_op(OP_LOAD_COL);
			r.cidx  = 7'($urandom_range(COLS - 1));
			r.cdata = punch_pattern();
			issue_op(r);
		end
		if (rdr_state != RS_IDLE || tick_armed) begin
			r = random_op(OP_CONTROL);
			r.chan = ch_setting;
			r.ctl  = CTL_SKIP_CARD;
			issue_op(r);
		end
		r = random_op(OP_CONNECT);
		r.chan   = ch_setting;
		r.hopper = 1'b1;
		issue_op(r);
		steps = 0;
		// the card is left unfinished once the phase has used up its transactions
		while (rdr_state != RS_IDLE && steps < 600 &&
				accepted_ops - phase_start < PHASE_OPS) begin
			case ($urandom_range(99)) inside
				[0:39]: begin
					r = random_op(OP_READ_CHAR);
					r.fetch_ok = ($urandom_range(19) != 0);
					issue_op(r);
				end
				[40:74]: issue_op(random_op(OP_TICK));
				[75:81]: begin
					r = random_op(OP_SKIP_TEST);
					r.chan = ch_setting;
					case ($urandom_range(3))
						0: r.cond = SKC_FEED;
						1: r.cond = SKC_READY;
						2: r.cond = SKC_FIRST;
						default: r.cond = 6'($urandom());
					endcase
					issue_op(r);
				end
				[82:87]: begin
					// mode change in the middle of a card
					issue_op(random_op(OP_DISCONNECT));
					r = random_op(OP_CONNECT);
					r.chan = ch_setting;
					issue_op(r);
				end
				[88:90]: begin
					r = random_op(OP_CONTROL);
					r.chan = ch_setting;
					if ($urandom_range(9) == 0)
						r.ctl = CTL_SKIP_CARD;
					issue_op(r);
				end
				[91:94]: begin
					r = random_op(OP_LOAD_COL);
					r.cidx  = 7'($urandom_range(COLS - 1));
					r.cdata = punch_pattern();
					issue_op(r);
				end
				default: issue_op(random_op(op_t'($urandom_range(7))));
			endcase
			steps++;
		end
	endtask

	initial begin
		logic [2:0]  chan_pick;

		// error codes, field extremes, skip tests, decode corners, failed fetch
		plan_row(OP_WRITE,      0, 0, 0, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_WRITE_REJ, 0));
		plan_row(OP_CONNECT,    3, 0, 1, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_WRONG_CH, 0));
		plan_row(OP_CONTROL,    7, 0, 0, 1, CTL_SKIP_CARD, 0, 'h000, 1,
			outcome(0, 0, 0, ERR_WRONG_CH, 0));
		plan_row(OP_SKIP_TEST,  1, 0, 1, 1, SKC_FEED, 0, 'h000, 1,
			outcome(0, 0, 0, ERR_WRONG_CH, 0));
		plan_row(OP_SKIP_TEST,  0, 0, 1, 1, SKC_FEED, 0, 'h000, 1, outcome(0, 0, 1, ERR_OK, 0));
		plan_row(OP_SKIP_TEST,  0, 0, 0, 1, SKC_READY, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_SKIP_TEST,  0, 1, 1, 1, 63, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_TICK,       0, 0, 0, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_LOAD_COL,   0, 0, 0, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_LOAD_COL,   0, 0, 0, 1, 0, 1, 'hfff, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_LOAD_COL,   0, 0, 0, 1, 0, 2, 'h801, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_LOAD_COL,   0, 0, 0, 1, 0, 79, 'h200, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_LOAD_COL,   0, 0, 0, 1, 0, 127, 'habc, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_CONNECT,    0, 0, 1, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 0));
		plan_row(OP_CONNECT,    0, 1, 1, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_BUSY, 0));
		plan_row(OP_TICK,       0, 0, 0, 1, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 4'b0001));
		plan_row(OP_SKIP_TEST,  0, 0, 0, 1, SKC_FIRST, 0, 'h000, 0, '0);
		plan_row(OP_READ_CHAR,  0, 0, 0, 1, 0, 0, 'h000, 1, outcome(6'o60, 1, 0, ERR_OK, 0));
		plan_row(OP_READ_CHAR,  0, 0, 0, 1, 0, 0, 'h000, 1, outcome(6'o77, 1, 0, ERR_OK, 0));
		plan_row(OP_SKIP_TEST,  0, 0, 0, 1, SKC_FIRST, 0, 'h000, 0, '0);
		plan_row(OP_DISCONNECT, 5, 0, 0, 1, 0, 0, 'h000, 0, '0);
		plan_row(OP_CONNECT,    0, 1, 0, 1, 0, 0, 'h000, 0, '0);
		plan_row(OP_READ_CHAR,  0, 0, 0, 1, 0, 0, 'h000, 0, '0);
		plan_row(OP_CONNECT,    0, 0, 0, 1, 0, 0, 'h000, 0, '0);
		plan_row(OP_CONTROL,    0, 0, 0, 1, 15, 0, 'h000, 0, '0);
		plan_row(OP_CONTROL,    0, 0, 0, 1, CTL_SKIP_CARD, 0, 'h000, 1,
			outcome(0, 0, 0, ERR_OK, 4'b1010));
		plan_row(OP_CONNECT,    0, 0, 1, 1, 0, 0, 'h000, 0, '0);
		plan_row(OP_READ_CHAR,  0, 0, 0, 0, 0, 0, 'h000, 1, outcome(0, 0, 0, ERR_OK, 4'b1110));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			drive_op(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);

		for (int p = 0; p < 3; p++) begin
			drain_results();
			case (p)
				0: begin
					chan_pick = 3'd7;
					send_idle_pct = 21;
					recv_idle_pct = 46;
				end
				1: begin
					chan_pick = 3'd0;
					send_idle_pct = 46;
					recv_idle_pct = 21;
				end
				default: begin
					chan_pick = 3'($urandom_range(1, 6));
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_channel(chan_pick);
			phase_start = accepted_ops;
			while (accepted_ops - phase_start < PHASE_OPS) begin
				if ($urandom_range(99) < 3)
					drain_results();
				if ($urandom_range(99) < 75)
					read_one_card();
				else
					repeat ($urandom_range(1, 8))
						issue_op(random_op(op_t'($urandom_range(7))));
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// every result transaction is checked against the oldest prediction
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", char_out, 0);
			end else begin
				want = expected_results.pop_front();
				if (char_out !== want.ch)
					report_mismatch("char_out", char_out, want.ch);
				if (char_valid !== want.chv)
					report_mismatch("char_valid", char_valid, want.chv);
				if (skip_taken !== want.skip)
					report_mismatch("skip_taken", skip_taken, want.skip);
				if (error_code !== want.err)
					report_mismatch("error_code", error_code, want.err);
				if (end_of_record !== want.eor)
					report_mismatch("end_of_record", end_of_record, want.eor);
				if (error_flag !== want.eflag)
					report_mismatch("error_flag", error_flag, want.eflag);
				if (disconnect_req !== want.disc)
					report_mismatch("disconnect_req", disconnect_req, want.disc);
				if (transfer_request !== want.xfer)
					report_mismatch("transfer_request", transfer_request, want.xfer);
			end
		end
	end

	// ends the run when neither channel has moved a transaction for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
